>>> rtl/mcd_pkg.sv
// shared types, codes and constant tables for the multibyte character decoder
// no dependencies; imported by every module of the block
package mcd_pkg;

  // coding mode register codes (code 3 behaves like raw bytes)
  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_UTF8 = 2'd1;
  localparam logic [1:0] MODE_GB   = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_UTF8;

  localparam int CODE_W  = 31;
  localparam int BYTES_W = 3;

  // gb2312 byte window
  localparam logic [7:0] GB_LOW  = 8'hA1;
  localparam logic [7:0] GB_HIGH = 8'hFE;

  // result queue geometry (depth is a power of two, pointers wrap naturally)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // one result beat
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eot;
    logic              last;
  } mcd_res_t;

  // decoder outcome for one byte
  typedef struct packed {
    logic [1:0]         count;
    mcd_res_t           res0;
    mcd_res_t           res1;
    logic [CODE_W-1:0]  pend_value;
    logic [BYTES_W-1:0] pend_bytes;
  } mcd_dec_t;

  // bits of the held value kept before the next 6-bit shift
  function automatic logic [24:0] keep_mask(input logic [BYTES_W-1:0] nbytes);
    logic [24:0] m;
    case (nbytes)
      3'd1:    m = 25'h000003f;
      3'd2:    m = 25'h00007ff;
      3'd3:    m = 25'h000ffff;
      3'd4:    m = 25'h01fffff;
      3'd5:    m = 25'h1ffffff;
      default: m = 25'h0000000;
    endcase
    return m;
  endfunction

  // marker bit that says another continuation byte may follow
  function automatic logic [CODE_W-1:0] more_bit(input logic [BYTES_W-1:0] nbytes);
    logic [CODE_W-1:0] m;
    case (nbytes)
      3'd2:    m = 31'h00000800;
      3'd3:    m = 31'h00010000;
      3'd4:    m = 31'h00200000;
      3'd5:    m = 31'h04000000;
      default: m = 31'h00000000;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/mcd_decode.sv
// per-byte decode: combines the incoming byte with the pending character
// depends on mcd_pkg
module mcd_decode (
  input  logic [7:0]                  text_byte,
  input  logic [1:0]                  mode,
  input  logic [mcd_pkg::CODE_W-1:0]  pend_value,
  input  logic [mcd_pkg::BYTES_W-1:0] pend_bytes,
  output mcd_pkg::mcd_dec_t           dec
);
  import mcd_pkg::*;

  logic [CODE_W-1:0]  ext_value;
  logic [BYTES_W-1:0] ext_bytes;
  logic               is_cont;
  logic               is_lead;
  logic               is_gb;

  // continuation candidate and byte classes
  always_comb begin
    ext_value = {pend_value[24:0] & keep_mask(pend_bytes), text_byte[5:0]};
    ext_bytes = pend_bytes + 3'd1;
    is_cont   = (text_byte[7:6] == 2'b10);
    is_lead   = (text_byte[7:6] == 2'b11);
    is_gb     = (text_byte >= GB_LOW) && (text_byte <= GB_HIGH);
  end

  // decode decision
  always_comb begin
    logic done;
    done = 1'b0;
    dec = '0;
    dec.pend_value = pend_value;
    dec.pend_bytes = pend_bytes;

    if (pend_bytes != 3'd0) begin
      if (mode == MODE_UTF8 && is_cont && pend_bytes <= 3'd5) begin
        done = 1'b1;
        if (ext_bytes <= 3'd5 && (ext_value & more_bit(ext_bytes)) != '0) begin
          // still room for another continuation byte
          dec.pend_value = ext_value;
          dec.pend_bytes = ext_bytes;
        end else begin
          dec.pend_value = '0;
          dec.pend_bytes = '0;
          dec.count      = 2'd1;
          dec.res0.code  = ext_value;
        end
      end else if (mode == MODE_GB && pend_bytes == 3'd1 && is_gb) begin
        done = 1'b1;
        dec.pend_value = '0;
        dec.pend_bytes = '0;
        dec.count      = 2'd1;
        dec.res0.code  = {15'd0, pend_value[7:0], text_byte};
      end else begin
        // byte does not fit: flush the pending character first
        dec.pend_value = '0;
        dec.pend_bytes = '0;
        dec.count      = 2'd1;
        dec.res0.code  = pend_value;
      end
    end

    // fresh byte
    if (!done) begin
      if (text_byte == 8'd0) begin
        if (dec.count == 2'd0) begin
          dec.res0.code = '0;
          dec.res0.eot  = 1'b1;
        end else begin
          dec.res1.code = '0;
          dec.res1.eot  = 1'b1;
        end
        dec.count = dec.count + 2'd1;
      end else if ((mode == MODE_UTF8 && is_lead) || (mode == MODE_GB && is_gb)) begin
        dec.pend_value = {23'd0, text_byte};
        dec.pend_bytes = 3'd1;
      end else begin
        if (dec.count == 2'd0) begin
          dec.res0.code = {23'd0, text_byte};
        end else begin
          dec.res1.code = {23'd0, text_byte};
        end
        dec.count = dec.count + 2'd1;
      end
    end

    // mark the final result of this byte
    dec.res0.last = (dec.count == 2'd1);
    dec.res1.last = 1'b1;
  end

endmodule

>>> rtl/mcd_outq.sv
// result queue: takes up to two result beats per cycle, hands out one
// while out_ready is high; depends on mcd_pkg
module mcd_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  mcd_pkg::mcd_res_t push_res0,
  input  mcd_pkg::mcd_res_t push_res1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output mcd_pkg::mcd_res_t out_res
);
  import mcd_pkg::*;

  mcd_res_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = slots[rd_ptr];
  // room for a full two-beat burst
  assign room      = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  assign count_next = count + {1'b0, push_count} - {{(QCNT_W-1){1'b0}}, pop};

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {{(QPTR_W-1){1'b0}}, pop};
      count  <= count_next;
    end
  end

  // slot writes
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_res0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push_res1;
    end
  end

endmodule

>>> rtl/multibyte_char_decoder_core.sv
// top level of the multibyte character decoder (raw, utf-8, gb2312)
// depends on mcd_pkg, mcd_decode and mcd_outq
//
//  channel | signals                                    | beat when
//  --------+--------------------------------------------+----------------------
//  input   | in_valid, in_ready, text_byte              | in_valid & in_ready
//  output  | out_valid, out_ready, char_code,           | out_valid & out_ready
//          | end_of_text, last_of_run                   |
//  config  | cfg_we, cfg_wdata (coding_mode)            | cfg_we
//
// a byte is decoded in the cycle it is accepted; its results are written into the
// result queue and leave it at one beat per cycle while out_ready is high
// a byte yields zero, one or two results, so sustained input rate is one byte
// per cycle while each byte gives at most one result, else the output port limits it
// in_ready drops when the four-entry result queue has fewer than two free slots
// reset empties the queue, clears the pending character and selects utf-8
// a config write drops the pending character without emitting it
module multibyte_char_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  text_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mcd_pkg::CODE_W-1:0]  char_code,
  output logic                        end_of_text,
  output logic                        last_of_run,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata
);
  import mcd_pkg::*;

  logic [1:0]         coding_mode;
  logic [CODE_W-1:0]  pend_value;
  logic [BYTES_W-1:0] pend_bytes;
  mcd_dec_t           dec;
  mcd_res_t           out_res;
  logic               room;
  logic               in_beat;
  logic [1:0]         push_count;

  assign in_ready   = room;
  assign in_beat    = in_valid && room;
  assign push_count = in_beat ? dec.count : 2'd0;

  // byte decode
  mcd_decode u_decode (
    .text_byte  (text_byte),
    .mode       (coding_mode),
    .pend_value (pend_value),
    .pend_bytes (pend_bytes),
    .dec        (dec)
  );

  // mode register and pending character
  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode <= MODE_RESET;
      pend_value  <= '0;
      pend_bytes  <= '0;
    end else if (cfg_we) begin
      coding_mode <= cfg_wdata;
      pend_value  <= '0;
      pend_bytes  <= '0;
    end else if (in_beat) begin
      pend_value  <= dec.pend_value;
      pend_bytes  <= dec.pend_bytes;
    end
  end

  // result queue
  mcd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_res0  (dec.res0),
    .push_res1  (dec.res1),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign char_code   = out_res.code;
  assign end_of_text = out_res.eot;
  assign last_of_run = out_res.last;

endmodule

>>> rtl/mcd_checker.sv
// port-level checks for multibyte_char_decoder_core, attached by bind
// depends on mcd_pkg and the top level's ports
module mcd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mcd_pkg::CODE_W-1:0] char_code,
  input logic                       end_of_text,
  input logic                       last_of_run
);
  import mcd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code)
      && $stable(end_of_text) && $stable(last_of_run))
    else $error("stalled result beat changed");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result visible right after reset");

  // the terminator carries a zero code and closes its run
  a_eot_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> char_code == '0 && last_of_run)
    else $error("terminator beat malformed");

  // the second result of a byte is queued with the first
  a_run_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("run broken after a non-final result");

endmodule

bind multibyte_char_decoder_core mcd_checker u_mcd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .char_code   (char_code),
  .end_of_text (end_of_text),
  .last_of_run (last_of_run)
);

>>> sim/char_decode_checker.sv
`timescale 1ns / 100ps
// watcher for the multibyte character decoder: predicts the characters of every
// accepted byte beat and compares each output beat in order; depends on mcd_pkg
module char_decode_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 text_byte,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [mcd_pkg::CODE_W-1:0] char_code,
  input  logic                       end_of_text,
  input  logic                       last_of_run,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  output int                         mismatches,
  output int                         results_owed
);
  import mcd_pkg::*;

  logic [1:0]        coding;
  logic [CODE_W-1:0] held_code;
  logic [2:0]        held_len;
  mcd_res_t          expected_chars[$];
  mcd_res_t          want;

  // low bits of the held code that survive the next six-bit shift
  function automatic logic [CODE_W-1:0] kept_bits(input logic [2:0] len);
    logic [CODE_W-1:0] m;
    case (len)
      3'd1:    m = 31'h0000003f;
      3'd2:    m = 31'h000007ff;
      3'd3:    m = 31'h0000ffff;
      3'd4:    m = 31'h001fffff;
      3'd5:    m = 31'h01ffffff;
      default: m = 31'h00000000;
    endcase
    return m;
  endfunction

  // bit that still announces another continuation byte
  function automatic logic [CODE_W-1:0] more_flag(input logic [2:0] len);
    logic [CODE_W-1:0] m;
    case (len)
      3'd2:    m = 31'h00000800;
      3'd3:    m = 31'h00010000;
      3'd4:    m = 31'h00200000;
      3'd5:    m = 31'h04000000;
      default: m = 31'h00000000;
    endcase
    return m;
  endfunction

  function automatic logic gb_range(input logic [7:0] b);
    return (b >= GB_LOW) && (b <= GB_HIGH);
  endfunction

  // decode one byte against the held character, queue the characters it yields
  function automatic void predict_chars(input logic [7:0] b);
    logic [CODE_W-1:0] v;
    logic [2:0]        len;
    logic              done;
    int                first;
    mcd_res_t          r;
    first = expected_chars.size();
    done  = 1'b0;
    if (held_len != 3'd0) begin
      v         = held_code;
      len       = held_len;
      held_code = '0;
      held_len  = '0;
      if (coding == MODE_UTF8 && b[7:6] == 2'b10) begin
        // continuation byte extends the held code
        v    = ((v & kept_bits(len)) << 6) | CODE_W'(b[5:0]);
        len  = len + 3'd1;
        done = 1'b1;
        if (len <= 3'd5 && (v & more_flag(len)) != '0) begin
          held_code = v;
          held_len  = len;
        end else begin
          expected_chars.push_back({v, 1'b0, 1'b0});
        end
      end else if (coding == MODE_GB && len == 3'd1 && gb_range(b)) begin
        expected_chars.push_back({((v & 31'h000000ff) << 8) | CODE_W'(b), 1'b0, 1'b0});
        done = 1'b1;
      end else begin
        // byte does not fit: flush the held character, then decode afresh
        expected_chars.push_back({v, 1'b0, 1'b0});
      end
    end
    if (!done) begin
      if (b == 8'h00) begin
        expected_chars.push_back({CODE_W'(0), 1'b1, 1'b0});
      end else if (coding == MODE_UTF8 && b[7:6] == 2'b11) begin
        held_code = CODE_W'(b);
        held_len  = 3'd1;
      end else if (coding == MODE_GB && gb_range(b)) begin
        held_code = CODE_W'(b);
        held_len  = 3'd1;
      end else begin
        expected_chars.push_back({CODE_W'(b), 1'b0, 1'b0});
      end
    end
    // final character of this byte carries the last flag
    if (expected_chars.size() > first) begin
      r = expected_chars.pop_back();
      r.last = 1'b1;
      expected_chars.push_back(r);
    end
  endfunction

  // track config writes and byte beats, compare result beats
  always @(posedge clk) begin
    if (rst) begin
      coding     = MODE_RESET;
      held_code  = '0;
      held_len   = '0;
      mismatches = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we) begin
        coding    = cfg_wdata;
        held_code = '0;
        held_len  = '0;
      end
      if (in_valid && in_ready) begin
        predict_chars(text_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual code=%h eot=%b last=%b",
                   $time, char_code, end_of_text, last_of_run);
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code || end_of_text !== want.eot ||
              last_of_run !== want.last) begin
            mismatches++;
            if (char_code !== want.code)
              $display("%0t: char_code expected %h actual %h", $time, want.code, char_code);
            if (end_of_text !== want.eot)
              $display("%0t: end_of_text expected %b actual %b", $time, want.eot, end_of_text);
            if (last_of_run !== want.last)
              $display("%0t: last_of_run expected %b actual %b", $time, want.last, last_of_run);
          end
        end
      end
    end
    results_owed = expected_chars.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// stimulus and verdict for multibyte_char_decoder_core: directed and random byte
// streams in every coding; depends on mcd_pkg, the core rtl and char_decode_checker
module testbench;
  import mcd_pkg::*;

  localparam logic [1:0] MODE_UNDEF    = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 8;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic [7:0]        text_byte   = 8'h00;
  logic              out_ready   = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [1:0]        cfg_wdata   = 2'd0;
  logic              in_ready;
  logic              out_valid;
  logic [CODE_W-1:0] char_code;
  logic              end_of_text;
  logic              last_of_run;
  int                mismatches;
  int                results_owed;
  int                cycle_count   = 0;
  int                bytes_sent    = 0;
  int                stall_left    = 0;
  int                sink_roll     = 0;
  logic              sender_steady = 1'b0;

  always #5 clk = ~clk;

  multibyte_char_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  char_decode_checker decode_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .end_of_text  (end_of_text),
    .last_of_run  (last_of_run),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result receiver: short and long stalls, with stall-free stretches
  always @(negedge clk) begin
    sink_roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((cycle_count % 600) < 120 || sink_roll >= 25) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= (sink_roll < 3) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // one byte beat; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid  = 1'b0;
      text_byte = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    text_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // coding change once the decoder has gone quiet
  task automatic write_mode(input logic [1:0] mode);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly complete sequences, some cut short, some stray bytes and zeros
  task automatic send_utf8_unit();
    int         r;
    int         len;
    int         k;
    int         i;
    logic [7:0] lead;
    r   = $urandom_range(0, 99);
    len = $urandom_range(1, 6);
    case (len)
      1:       lead = 8'($urandom_range(1, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      4:       lead = 8'hF0 | 8'($urandom_range(0, 7));
      5:       lead = 8'hF8 | 8'($urandom_range(0, 3));
      default: lead = 8'hFC | 8'($urandom_range(0, 3));
    endcase
    if (r < 75) begin
      send_byte(lead);
      for (i = 1; i < len; i++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
    end else if (r < 85) begin
      send_byte(lead);
      k = (len > 1) ? $urandom_range(0, len - 2) : 0;
      for (i = 0; i < k; i++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
    end else if (r < 94) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(8'h00);
    end
  endtask

  // mostly valid pairs, some lone first bytes, broken pairs, noise and zeros
  task automatic send_gb_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_byte(8'($urandom_range(GB_LOW, GB_HIGH)));
      send_byte(8'($urandom_range(GB_LOW, GB_HIGH)));
    end else if (r < 80) begin
      send_byte(8'($urandom_range(GB_LOW, GB_HIGH)));
    end else if (r < 88) begin
      send_byte(8'($urandom_range(GB_LOW, GB_HIGH)));
      send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, GB_LOW - 1)));
    end else if (r < 96) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(8'h00);
    end
  endtask

  task automatic send_raw_unit();
    send_byte(($urandom_range(0, 99) < 6) ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [1:0] mode, input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      sender_steady = ((bytes_sent % 100) < 15);
      if (mode == MODE_UTF8) send_utf8_unit();
      else if (mode == MODE_GB) send_gb_unit();
      else send_raw_unit();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // utf-8 at its reset setting: zero code from data, six-byte FF lead,
    // stray continuation, zero byte and non-continuation flushing a held lead
    send_byte(8'hC0); send_byte(8'h80);
    send_byte(8'hFF);
    repeat (5) send_byte(8'hBF);
    send_byte(8'h80);
    send_byte(8'hC3); send_byte(8'h00);
    send_byte(8'hE2); send_byte(8'h41);
    // held character dropped by the coding change
    send_byte(8'hF0); send_byte(8'h9F);
    write_mode(MODE_RAW);
    send_byte(8'hFF); send_byte(8'h00);
    // gb2312: window edges, broken pair, zero after a first byte
    write_mode(MODE_GB);
    send_byte(8'hA1); send_byte(8'hFE);
    send_byte(8'hB0); send_byte(8'h42);
    send_byte(8'hFE); send_byte(8'h00);
    // undefined coding behaves as raw
    write_mode(MODE_UNDEF);
    send_byte(8'h80);

    // random phases across all codings
    write_mode(MODE_UTF8);
    run_phase(MODE_UTF8, 300);
    write_mode(MODE_GB);
    run_phase(MODE_GB, 200);
    write_mode(MODE_RAW);
    run_phase(MODE_RAW, 80);
    write_mode(MODE_UNDEF);
    run_phase(MODE_UNDEF, 40);
    write_mode(MODE_UTF8);
    run_phase(MODE_UTF8, 150);
    write_mode(MODE_GB);
    run_phase(MODE_GB, 80);

    // drain and settle
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> multibyte_char_decoder_core.f
rtl/mcd_pkg.sv
rtl/mcd_decode.sv
rtl/mcd_outq.sv
rtl/multibyte_char_decoder_core.sv
rtl/mcd_checker.sv
sim/char_decode_checker.sv
sim/testbench.sv
